// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
// tcs_pkg: constants, codes and types of the telnet command stripper
// no dependencies; imported by telnet_command_stripper_unit
package tcs_pkg;

    localparam int NUM_OPTIONS = 256;
    localparam int ARG_LEN     = 32;

    localparam int OPT_W       = $clog2(NUM_OPTIONS);
    localparam int LEN_W       = $clog2(ARG_LEN + 1);
    localparam int STORE_DEPTH = NUM_OPTIONS * ARG_LEN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 16;
    localparam int CMP_W       = 10;

    localparam logic [7:0] IAC  = 8'd255;
    localparam logic [7:0] DONT = 8'd254;
    localparam logic [7:0] DO   = 8'd253;
    localparam logic [7:0] WONT = 8'd252;
    localparam logic [7:0] WILL = 8'd251;
    localparam logic [7:0] SB   = 8'd250;

    localparam logic [7:0] OPT_ECHO     = 8'd1;
    localparam logic [7:0] OPT_NAOCRD   = 8'd10;
    localparam logic [7:0] OPT_LINEMODE = 8'd34;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        CODE_NONE,
        CODE_DO,
        CODE_DONT,
        CODE_WILL,
        CODE_WONT
    } opt_code_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_IAC,
        ST_DO,
        ST_DONT,
        ST_WILL,
        ST_WONT,
        ST_SB,
        ST_DATA,
        ST_END
    } parse_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOCAL,
        OP_PEER,
        OP_SB,
        OP_DATA,
        OP_QUERY
    } op_t;

    typedef struct packed {
        opt_code_t        local_code;
        opt_code_t        peer_code;
        logic [LEN_W-1:0] len;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic entry_t reset_entry(logic [OPT_W-1:0] opt);
        entry_t e;
        e.local_code = CODE_NONE;
        e.peer_code  = CODE_NONE;
        e.len        = '0;
        if (opt == OPT_W'(OPT_ECHO) || opt == OPT_W'(OPT_NAOCRD))
        begin
            e.local_code = CODE_WILL;
        end
        if (opt == OPT_W'(OPT_LINEMODE))
        begin
            e.peer_code = CODE_DO;
        end
        return e;
    endfunction

endpackage

// ===== rtl/tcs_ram.sv =====
`timescale 1ns / 1ps
// tcs_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/telnet_command_stripper_unit.sv =====
`timescale 1ns / 1ps
// telnet_command_stripper_unit: top level of the telnet command stripper
// depends on tcs_pkg and tcs_ram
//
// Takes one word per cycle and returns exactly one result word for each, in order:
// plain bytes pass through, IAC sequences are removed, DO/DONT/WILL/WONT update the
// option tables and SB arguments go to the argument store; query words (tuser = 1)
// read back one option entry and one argument byte. A word is accepted every cycle
// while results drain; it passes through the option read stage (registered ram
// read, then read-modify-write of the option entry with forwarding between
// neighboring words) and then waits in the output register until it is taken. Option
// entries start from their reset values through per-entry valid flops, so no clearing
// pass is needed after reset. Argument bytes never written read back only if below
// the stored length.
module telnet_command_stripper_unit
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], arg_index[12:8], zero fill
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last_in_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // pass_valid, out_byte, kept_count, local_code,
                                   // peer_code, arg_length, arg_byte, zero fill
);

    logic             accept;
    logic             in_mode;
    logic [7:0]       in_byte;
    logic [4:0]       in_idx;
    logic             in_range;
    logic [OPT_W-1:0] in_opt;

    parse_state_t     state_reg, state_next;
    logic [OPT_W-1:0] wopt_reg, wopt_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] kept_shown;

    op_t              op;
    opt_code_t        code;
    logic             pass;
    logic [OPT_W-1:0] rd_opt;
    logic [STORE_AW-1:0] s_raddr;
    logic [4:0]       idx_clamped;

    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    opt_code_t           s1_code_reg;
    logic [OPT_W-1:0]    s1_opt_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_pass_reg;
    logic [CNT_W-1:0]    s1_kept_reg;
    logic [4:0]          s1_idx_reg;
    logic                s1_qok_reg;
    logic                s1_efwd_reg;
    entry_t              s1_efwd_data_reg;
    logic                s1_sfwd_reg;
    logic [7:0]          s1_sfwd_data_reg;
    logic                s1_fire;

    logic [NUM_OPTIONS-1:0] ent_valid_reg;

    logic [ENTRY_W-1:0]  e_rdata;
    logic [7:0]          s_rdata;
    entry_t              ent_old, ent_new;
    logic                e_we, s_we;
    logic [STORE_AW-1:0] s_waddr;
    logic [7:0]          store_byte;

    logic [2:0]          q_local, q_peer;
    logic [5:0]          q_len;
    logic [7:0]          q_byte, o_byte;

    logic                out_valid_reg;
    logic [47:0]         out_data_reg;

    assign in_mode  = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign in_idx   = s_tdata[12:8];
    assign in_range = CMP_W'(in_byte) < CMP_W'(NUM_OPTIONS);
    assign in_opt   = in_byte[OPT_W-1:0];

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;

    // parser, decided at acceptance
    always_comb
    begin
        state_next = state_reg;
        wopt_next  = wopt_reg;
        op         = OP_NONE;
        code       = CODE_NONE;
        pass       = 1'b0;
        rd_opt     = in_opt;
        if (in_mode)
        begin
            op = OP_QUERY;
        end
        else
        begin
            case (state_reg)
                ST_START:
                begin
                    if (in_byte == IAC)
                    begin
                        state_next = ST_IAC;
                    end
                    else
                    begin
                        pass = 1'b1;
                    end
                end
                ST_IAC:
                begin
                    if (in_byte == DO)
                    begin
                        state_next = ST_DO;
                    end
                    else if (in_byte == DONT)
                    begin
                        state_next = ST_DONT;
                    end
                    else if (in_byte == WILL)
                    begin
                        state_next = ST_WILL;
                    end
                    else if (in_byte == WONT)
                    begin
                        state_next = ST_WONT;
                    end
                    else if (in_byte == SB)
                    begin
                        state_next = ST_SB;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
                ST_DO:
                begin
                    op         = in_range ? OP_LOCAL : OP_NONE;
                    code       = CODE_DO;
                    state_next = ST_START;
                end
                ST_DONT:
                begin
                    op         = in_range ? OP_LOCAL : OP_NONE;
                    code       = CODE_DONT;
                    state_next = ST_START;
                end
                ST_WILL:
                begin
                    op         = in_range ? OP_PEER : OP_NONE;
                    code       = CODE_WILL;
                    state_next = ST_START;
                end
                ST_WONT:
                begin
                    op         = in_range ? OP_PEER : OP_NONE;
                    code       = CODE_WONT;
                    state_next = ST_START;
                end
                ST_SB:
                begin
                    if (in_range)
                    begin
                        wopt_next  = in_opt;
                        op         = OP_SB;
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
                ST_DATA:
                begin
                    if (in_byte == IAC)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        op     = OP_DATA;
                        rd_opt = wopt_reg;
                    end
                end
                default:
                begin
                    state_next = ST_START;
                end
            endcase
        end
    end

    always_comb
    begin
        kept_shown = kept_reg;
        if (pass && kept_reg != CNT_MAX)
        begin
            kept_shown = kept_reg + CNT_W'(1);
        end
        kept_next = kept_reg;
        if (accept)
        begin
            if (in_mode)
            begin
                kept_next = kept_reg;
            end
            else if (s_tlast)
            begin
                kept_next = '0;
            end
            else
            begin
                kept_next = kept_shown;
            end
        end
    end

    assign idx_clamped = (CMP_W'(in_idx) < CMP_W'(ARG_LEN)) ? in_idx : 5'd0;
    assign s_raddr     = STORE_AW'(in_opt) * STORE_AW'(ARG_LEN) + STORE_AW'(idx_clamped);

    // read-modify-write of the option entry
    always_comb
    begin
        if (s1_efwd_reg)
        begin
            ent_old = s1_efwd_data_reg;
        end
        else if (ent_valid_reg[s1_opt_reg])
        begin
            ent_old = entry_t'(e_rdata);
        end
        else
        begin
            ent_old = reset_entry(s1_opt_reg);
        end
        ent_new = ent_old;
        e_we    = 1'b0;
        s_we    = 1'b0;
        case (s1_op_reg)
            OP_LOCAL:
            begin
                ent_new.local_code = s1_code_reg;
                e_we               = 1'b1;
            end
            OP_PEER:
            begin
                ent_new.peer_code = s1_code_reg;
                e_we              = 1'b1;
            end
            OP_SB:
            begin
                ent_new.len = '0;
                e_we        = 1'b1;
            end
            OP_DATA:
            begin
                if (ent_old.len < LEN_W'(ARG_LEN))
                begin
                    ent_new.len = ent_old.len + LEN_W'(1);
                    e_we        = 1'b1;
                    s_we        = 1'b1;
                end
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    assign s_waddr    = STORE_AW'(s1_opt_reg) * STORE_AW'(ARG_LEN) + STORE_AW'(ent_old.len);
    assign store_byte = s1_sfwd_reg ? s1_sfwd_data_reg : s_rdata;

    always_comb
    begin
        q_local = 3'd0;
        q_peer  = 3'd0;
        q_len   = 6'd0;
        q_byte  = 8'd0;
        if (s1_op_reg == OP_QUERY && s1_qok_reg)
        begin
            q_local = ent_old.local_code;
            q_peer  = ent_old.peer_code;
            q_len   = 6'(ent_old.len);
            if (CMP_W'(s1_idx_reg) < CMP_W'(ent_old.len)
                && CMP_W'(s1_idx_reg) < CMP_W'(ARG_LEN))
            begin
                q_byte = store_byte;
            end
        end
        o_byte = s1_pass_reg ? s1_byte_reg : 8'd0;
    end

    tcs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_OPTIONS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we && s1_fire),
        .waddr (s1_opt_reg),
        .wdata (ent_new),
        .re    (accept),
        .raddr (rd_opt),
        .rdata (e_rdata)
    );

    tcs_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_arg_ram (
        .clk   (clk),
        .we    (s_we && s1_fire),
        .waddr (s_waddr),
        .wdata (s1_byte_reg),
        .re    (accept),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            wopt_reg      <= '0;
            kept_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            kept_reg <= kept_next;
            if (accept)
            begin
                state_reg <= state_next;
                wopt_reg  <= wopt_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (e_we && s1_fire)
            begin
                ent_valid_reg[s1_opt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg        <= op;
            s1_code_reg      <= code;
            s1_opt_reg       <= rd_opt;
            s1_byte_reg      <= in_byte;
            s1_pass_reg      <= pass;
            s1_kept_reg      <= in_mode ? kept_reg : kept_shown;
            s1_idx_reg       <= in_idx;
            s1_qok_reg       <= in_range;
            s1_efwd_reg      <= s1_fire && e_we && (s1_opt_reg == rd_opt);
            s1_efwd_data_reg <= ent_new;
            s1_sfwd_reg      <= s1_fire && s_we && (s_waddr == s_raddr);
            s1_sfwd_data_reg <= s1_byte_reg;
        end
        if (s1_fire)
        begin
            out_data_reg <= {3'b000, q_byte, q_len, q_peer, q_local, s1_kept_reg,
                             o_byte, s1_pass_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
